[design/mfc_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mfc_pkg: shared definitions of the multichannel FIR convolver
// Field widths, register indexes, parameter defaults and the control
// group that the top level sends down its row of tap cells.
// ---------------------------------------------------------------------------
package mfc_pkg;

  // Parameter defaults.
  localparam int DEF_MAX_TAPS    = 7;
  localparam int DEF_CHANNELS    = 2;
  localparam int DEF_SAMPLE_BITS = 16;

  // Fixed field widths.
  localparam int CH_W     = 1;
  localparam int IN_W     = 16;
  localparam int COEFF_W  = 16;
  localparam int SUM_W    = 34;
  localparam int TAP_W    = 3;
  localparam int IDX_W    = 3;
  localparam int NUM_COEFF = 7;

  // Register indexes of the configuration port.
  localparam logic [IDX_W-1:0] REG_TAP_COUNT = 3'd0;
  localparam logic [IDX_W-1:0] REG_COEFF_0   = 3'd1;

  localparam logic [TAP_W-1:0] TAP_COUNT_RESET = 3'd1;

  // Control that every tap cell sees in the same cycle.
  typedef struct packed {
    logic            load;   // product registers take new values
    logic            shift;  // a sample enters the delay line
    logic            clear;  // the selected channel is emptied instead
    logic [CH_W-1:0] ch;     // channel of the sample being issued
  } cell_ctrl_t;

endpackage

[design/multichannel_fir_convolver_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// multichannel_fir_convolver_core: per-channel linear convolution FIR
// Pipeline: an accepted sample beat's result is registered in the product
// registers, then the pair sums, then the output register, where it is valid.
// Throughput: one sample beat per cycle while the output is not stalled;
// after an end-marked beat with T active taps the input is not ready while
// the row issues the T-1 tail beats.
// Reset (synchronous, rst_n low): delay lines cleared, tap_count = 1,
// coeff_0 = 1, the other coefficients 0, pipeline empty.
// ---------------------------------------------------------------------------
//
// The datapath is a row of MAX_TAPS cells. Cell k receives the
// window sample w[k] from its left neighbor, multiplies it by coeff_k into a
// product register, and on each issued beat stores w[k] for the channel so
// that it becomes w[k+1] for the cell to its right. The row therefore is the
// delay line itself, split into one small store per cell.
//
// The tail of the full convolution is produced by issuing zero samples into
// the row: after k zero beats the window holds the original samples moved k
// places right, which is exactly the tail sum for k. A small flush sequencer
// issues T-1 such beats after an end-marked sample and clears the channel on
// the last one. The input is not ready while it runs.
//
// The products are summed in a two-level registered tree (pairs, then the
// final sum), and the final stage is the output register. Every stage has
// its own valid bit and moves when the stage after it is empty or moving,
// so new samples are still taken while a finished result waits.
// ---------------------------------------------------------------------------
module multichannel_fir_convolver_core #(
  parameter int MAX_TAPS    = mfc_pkg::DEF_MAX_TAPS,
  parameter int CHANNELS    = mfc_pkg::DEF_CHANNELS,
  parameter int SAMPLE_BITS = mfc_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration write port.
  input  logic                                cfg_wr_en,
  input  logic [mfc_pkg::IDX_W-1:0]           cfg_index,
  input  logic [mfc_pkg::COEFF_W-1:0]         cfg_wdata,
  // Sample channel.
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [mfc_pkg::CH_W-1:0]            in_channel_index,
  input  logic signed [mfc_pkg::IN_W-1:0]     in_sample_value,
  input  logic                                in_end_of_signal,
  // Result channel.
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mfc_pkg::CH_W-1:0]            out_channel,
  output logic signed [mfc_pkg::SUM_W-1:0]    out_conv_sum,
  output logic                                out_last_of_run
);
  import mfc_pkg::*;

  localparam int PW   = SAMPLE_BITS + COEFF_W;
  localparam int SUMW = PW + $clog2(MAX_TAPS);
  localparam int NP   = (MAX_TAPS + 1) / 2;

  // -------------------------------------------------------------------------
  // Configuration registers.
  // -------------------------------------------------------------------------
  logic [TAP_W-1:0]          tap_count_r;
  logic signed [COEFF_W-1:0] coeff_r [NUM_COEFF];
  logic [IDX_W-1:0]          coeff_sel;

  assign coeff_sel = cfg_index - REG_COEFF_0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= TAP_COUNT_RESET;
      for (int i = 0; i < NUM_COEFF; i++) begin
        coeff_r[i] <= (i == 0) ? COEFF_W'(1) : '0;
      end
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_TAP_COUNT: begin
          tap_count_r <= cfg_wdata[TAP_W-1:0];
        end
        default: begin
          coeff_r[coeff_sel] <= cfg_wdata;
        end
      endcase
    end
  end

  // A tap count of zero acts as one; one above MAX_TAPS acts as MAX_TAPS.
  logic [TAP_W-1:0] taps_eff;

  always_comb begin
    taps_eff = tap_count_r;
    if (tap_count_r == '0) begin
      taps_eff = TAP_W'(1);
    end else if (tap_count_r > TAP_W'(MAX_TAPS)) begin
      taps_eff = TAP_W'(MAX_TAPS);
    end
  end

  // -------------------------------------------------------------------------
  // Stage enables. A stage moves when the one after it is empty or moving.
  // -------------------------------------------------------------------------
  logic v1_r, v2_r;
  logic en1, en2, en3;

  assign en3 = !out_valid || out_ready;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  // -------------------------------------------------------------------------
  // Flush sequencer and issue control.
  // -------------------------------------------------------------------------
  logic             flush_r;
  logic [CH_W-1:0]  flush_ch_r;
  logic [TAP_W-1:0] flush_left_r;
  logic             in_fire, flush_step, issue, issue_last, issue_clear;
  logic [CH_W-1:0]  in_ch, issue_ch;

  assign in_ready   = en1 && !flush_r;
  assign in_fire    = in_valid && in_ready;
  assign flush_step = flush_r && en1;
  assign issue      = in_fire || flush_step;

  // A channel index beyond the configured count folds onto a real channel.
  assign in_ch    = (CHANNELS > 1) ? in_channel_index : CH_W'(0);
  assign issue_ch = flush_r ? flush_ch_r : in_ch;

  assign issue_last  = flush_r ? (flush_left_r == TAP_W'(1))
                               : (in_end_of_signal && taps_eff == TAP_W'(1));
  assign issue_clear = issue_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flush_r <= 1'b0;
    end else if (in_fire && in_end_of_signal && taps_eff != TAP_W'(1)) begin
      flush_r <= 1'b1;
    end else if (flush_step && flush_left_r == TAP_W'(1)) begin
      flush_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      flush_ch_r   <= in_ch;
      flush_left_r <= taps_eff - TAP_W'(1);
    end else if (flush_step) begin
      flush_left_r <= flush_left_r - TAP_W'(1);
    end
  end

  // -------------------------------------------------------------------------
  // Sample formatting: the low SAMPLE_BITS bits as two's complement.
  // -------------------------------------------------------------------------
  logic signed [SAMPLE_BITS-1:0] samp;

  if (SAMPLE_BITS <= IN_W) begin : g_samp_narrow
    assign samp = in_sample_value[SAMPLE_BITS-1:0];
  end else begin : g_samp_wide
    // The field carries no more bits, so the upper bits stay zero.
    assign samp = {{(SAMPLE_BITS-IN_W){1'b0}}, in_sample_value};
  end

  // -------------------------------------------------------------------------
  // Row of tap cells.
  // -------------------------------------------------------------------------
  cell_ctrl_t                    cell_ctrl;
  logic signed [SAMPLE_BITS-1:0] win  [MAX_TAPS];
  logic signed [PW-1:0]          prod [MAX_TAPS];

  assign cell_ctrl.load  = en1;
  assign cell_ctrl.shift = issue;
  assign cell_ctrl.clear = issue_clear;
  assign cell_ctrl.ch    = issue_ch;

  // Tail beats push zeros into the row.
  assign win[0] = flush_r ? '0 : samp;

  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
    if (k < MAX_TAPS - 1) begin : g_mid
      mfc_cell #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .CHANNELS    (CHANNELS),
        .KEEP        (1'b1)
      ) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (cell_ctrl),
        .win_in  (win[k]),
        .coeff   (coeff_r[k]),
        .tap_on  (taps_eff > TAP_W'(k)),
        .win_out (win[k+1]),
        .prod_r  (prod[k])
      );
    end else begin : g_end
      // The last tap never passes its sample on, so it keeps none.
      mfc_cell #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .CHANNELS    (CHANNELS),
        .KEEP        (1'b0)
      ) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (cell_ctrl),
        .win_in  (win[k]),
        .coeff   (coeff_r[k]),
        .tap_on  (taps_eff > TAP_W'(k)),
        .win_out (),
        .prod_r  (prod[k])
      );
    end
  end

  // Tags that travel beside the products.
  logic [CH_W-1:0] ch1_r, ch2_r;
  logic            last1_r, last2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      ch1_r   <= issue_ch;
      last1_r <= issue_last;
    end
  end

  // -------------------------------------------------------------------------
  // Adder tree, first level: pairs of products.
  // -------------------------------------------------------------------------
  logic signed [SUMW-1:0] part_r [NP];

  for (genvar i = 0; i < NP; i++) begin : g_pair
    if (2 * i + 1 < MAX_TAPS) begin : g_two
      always_ff @(posedge clk) begin
        if (en2) begin
          part_r[i] <= SUMW'(prod[2*i]) + SUMW'(prod[2*i+1]);
        end
      end
    end else begin : g_one
      always_ff @(posedge clk) begin
        if (en2) begin
          part_r[i] <= SUMW'(prod[2*i]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      ch2_r   <= ch1_r;
      last2_r <= last1_r;
    end
  end

  // -------------------------------------------------------------------------
  // Final sum into the output register.
  // -------------------------------------------------------------------------
  logic signed [SUMW-1:0]  sum_nxt;
  logic signed [SUM_W-1:0] sum_fit;

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < NP; i++) begin
      sum_nxt = sum_nxt + part_r[i];
    end
  end

  // The result field is 34 bits: wider sums wrap, narrower ones extend.
  if (SUMW >= SUM_W) begin : g_sum_cut
    assign sum_fit = sum_nxt[SUM_W-1:0];
  end else begin : g_sum_ext
    assign sum_fit = SUM_W'(sum_nxt);
  end

  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en3) begin
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2_r) begin
      out_channel     <= ch2_r;
      out_conv_sum    <= sum_fit;
      out_last_of_run <= last2_r;
    end
  end

  assign out_valid = out_valid_r;

  // -------------------------------------------------------------------------
  // Assertions.
  // -------------------------------------------------------------------------

  // An end-marked beat with a tail blocks the input on the next cycle.
  a_tail_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_end_of_signal && taps_eff != TAP_W'(1)) |=> !in_ready)
    else $error("input taken while a tail is pending");

  // The flush counter stays inside the tail length.
  a_flush_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    flush_r |-> (flush_left_r != '0 && flush_left_r <= TAP_W'(MAX_TAPS - 1)))
    else $error("flush counter out of range");

  // With every stage full and the output stalled, nothing new enters.
  a_full_pipe_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready && v2_r && v1_r) |-> !in_ready)
    else $error("input taken with the pipeline full");

  // A held result keeps its values while the output is stalled.
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_conv_sum)
                                   && $stable(out_last_of_run)))
    else $error("stalled result changed");

endmodule

[design/mfc_cell.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mfc_cell: one tap of the direct-form FIR row
// Multiplies the window sample it receives by its coefficient, and (when KEEP
// is set) keeps that sample per channel to hand to the next cell on the following beat.
// ---------------------------------------------------------------------------
module mfc_cell #(
  parameter int SAMPLE_BITS = 16,
  parameter int CHANNELS    = 2,
  parameter bit KEEP        = 1'b1
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  mfc_pkg::cell_ctrl_t                     ctrl,
  input  logic signed [SAMPLE_BITS-1:0]           win_in,
  input  logic signed [mfc_pkg::COEFF_W-1:0]      coeff,
  input  logic                                    tap_on,
  output logic signed [SAMPLE_BITS-1:0]           win_out,
  output logic signed [SAMPLE_BITS+mfc_pkg::COEFF_W-1:0] prod_r
);
  import mfc_pkg::*;

  localparam int PW = SAMPLE_BITS + COEFF_W;

  logic signed [PW-1:0] prod_nxt;

  // Taps beyond the active count contribute nothing.
  always_comb begin
    prod_nxt = '0;
    if (tap_on) begin
      prod_nxt = win_in * coeff;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      prod_r <= prod_nxt;
    end
  end

  if (KEEP) begin : g_store
    logic signed [SAMPLE_BITS-1:0] tap_r [CHANNELS];

    for (genvar c = 0; c < CHANNELS; c++) begin : g_ch
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          tap_r[c] <= '0;
        end else if (ctrl.shift && ctrl.ch == CH_W'(c)) begin
          tap_r[c] <= ctrl.clear ? '0 : win_in;
        end
      end
    end

    always_comb begin
      win_out = '0;
      for (int c = 0; c < CHANNELS; c++) begin
        if (ctrl.ch == CH_W'(c)) begin
          win_out = tap_r[c];
        end
      end
    end
  end else begin : g_nostore
    assign win_out = '0;
  end

endmodule
